### src/rmf_pkg.sv
// ----------------------------------------------------------------------------
// Running median filter package
// Widths and fixed constants shared by the filter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 6;
  localparam int MIN_WINDOW = 3;

endpackage : rmf_pkg

`default_nettype wire

### src/rmf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : rmf_ram

`default_nettype wire

### src/running_median_filter.sv
// ----------------------------------------------------------------------------
// Running median filter
// Median of the last window_size samples, one result per sample.
// ----------------------------------------------------------------------------
// The block keeps every stored sample in a sorted list, each entry tagged with
// its slot in the circular window. A sample of zero is stored as one. For each
// accepted sample one merge pass walks the old list from one RAM bank into the
// other: the entry whose tag matches the slot being overwritten is dropped and
// the new sample is inserted at its place in order. While the merged list is
// written out the walk counts the entries that belong to the current fill and
// captures the one at position fill/2, which is the median (the larger middle
// value for an even count). One sample occupies the block from its transfer
// until in_ready returns: the walk reads the L entries of the list (at most
// MAX_WINDOW) through the single read port of the list RAM, which delivers
// one entry per cycle except while the walk holds its address to insert the
// new sample; the block also presents the first address, closes the walk and
// hands the median to the output, waiting while an earlier one is untaken. The
// next sample may be transferred while a finished median still waits on the
// output. The window_size register
// is clamped to 3..MAX_WINDOW and should only be changed while the block is
// idle; after a change without reset, entries not written since reset give an
// undefined median until they are written. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_filter #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration
  input  wire logic                         cfg_write_en,
  input  wire logic [rmf_pkg::CFG_W-1:0]    cfg_window_size,
  // Sample input
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rmf_pkg::SAMPLE_W-1:0] in_sample,
  // Median output
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [rmf_pkg::SAMPLE_W-1:0] out_median_value
);

  import rmf_pkg::*;

  // Tag width indexes a window slot; count width can also hold MAX_WINDOW.
  localparam int IDXW  = $clog2(MAX_WINDOW);
  localparam int CNTW  = $clog2(MAX_WINDOW + 1);
  localparam int CMPW  = (CNTW > CFG_W) ? CNTW : CFG_W;
  localparam int ENTW  = SAMPLE_W + IDXW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_HOLD
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    wsize_r;
  logic [IDXW-1:0]     wpos_r;
  logic [CNTW-1:0]     fill_r;
  logic [CNTW-1:0]     len_r;
  logic                bank_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [IDXW-1:0]     tag_r;
  logic [CNTW-1:0]     rj_r;
  logic [CNTW-1:0]     wj_r;
  logic [CNTW-1:0]     mcnt_r;
  logic                ins_done_r;
  logic [SAMPLE_W-1:0] med_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_med_r;

  // ---------------------------------------------------------------------------
  // Window bookkeeping at the transfer of a sample
  // ---------------------------------------------------------------------------
  logic [CMPW-1:0]     wsize_ext;
  logic [CNTW-1:0]     win_len;
  logic [IDXW-1:0]     wpos_eff;
  logic [CNTW-1:0]     wpos_inc;
  logic [IDXW-1:0]     wpos_nxt;
  logic [CNTW-1:0]     fill_cut;
  logic [CNTW-1:0]     fill_nxt;
  logic [SAMPLE_W-1:0] smp_nxt;
  logic                in_xfer;

  assign wsize_ext = CMPW'(wsize_r);

  always_comb begin
    priority if (wsize_ext > CMPW'(MAX_WINDOW)) begin
      win_len = CNTW'(MAX_WINDOW);
    end else if (wsize_ext < CMPW'(MIN_WINDOW)) begin
      win_len = CNTW'(MIN_WINDOW);
    end else begin
      win_len = wsize_ext[CNTW-1:0];
    end
  end

  always_comb begin
    wpos_eff = (CNTW'(wpos_r) >= win_len) ? '0 : wpos_r;
    wpos_inc = CNTW'(wpos_eff) + CNTW'(1);
    wpos_nxt = (wpos_inc >= win_len) ? '0 : wpos_inc[IDXW-1:0];
    fill_cut = (fill_r > win_len) ? win_len : fill_r;
    fill_nxt = (fill_cut < win_len) ? fill_cut + CNTW'(1) : fill_cut;
    smp_nxt  = (in_sample == '0) ? SAMPLE_W'(1) : in_sample;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Sorted list, ping-pong between two banks
  // ---------------------------------------------------------------------------
  logic [ENTW-1:0]     rd_a;
  logic [ENTW-1:0]     rd_b;
  logic [ENTW-1:0]     rd_ent;
  logic [SAMPLE_W-1:0] cur_val;
  logic [IDXW-1:0]     cur_tag;
  logic                cur_valid;
  logic                take_new;
  logic                consume;
  logic                emit;
  logic [SAMPLE_W-1:0] emit_val;
  logic [IDXW-1:0]     emit_tag;
  logic [CNTW-1:0]     rd_addr;
  logic [CNTW-1:0]     med_pos;
  logic                walking;

  assign walking   = (state_r == ST_WALK);
  assign rd_ent    = bank_r ? rd_b : rd_a;
  assign cur_val   = rd_ent[ENTW-1:IDXW];
  assign cur_tag   = rd_ent[IDXW-1:0];
  assign cur_valid = (rj_r < len_r);
  assign med_pos   = fill_r >> 1;

  always_comb begin
    take_new = walking && !ins_done_r && (!cur_valid || (cur_val > smp_r));
    consume  = walking && !take_new && cur_valid;
    emit     = take_new || (consume && (cur_tag != tag_r));
    emit_val = take_new ? smp_r : cur_val;
    emit_tag = take_new ? tag_r : cur_tag;
    if (consume) begin
      rd_addr = rj_r + CNTW'(1);
    end else if (walking) begin
      rd_addr = rj_r;
    end else begin
      rd_addr = '0;
    end
  end

  // Bank select low: read bank A, write bank B.
  rmf_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_WINDOW)
  ) u_list_a (
    .clk   (clk),
    .we    (emit && bank_r),
    .waddr (wj_r[IDXW-1:0]),
    .wdata ({emit_val, emit_tag}),
    .raddr (rd_addr[IDXW-1:0]),
    .rdata (rd_a)
  );

  rmf_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_WINDOW)
  ) u_list_b (
    .clk   (clk),
    .we    (emit && !bank_r),
    .waddr (wj_r[IDXW-1:0]),
    .wdata ({emit_val, emit_tag}),
    .raddr (rd_addr[IDXW-1:0]),
    .rdata (rd_b)
  );

  // ---------------------------------------------------------------------------
  // Sequencer, state and registered outputs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wsize_r     <= CFG_W'(MIN_WINDOW);
      wpos_r      <= '0;
      fill_r      <= '0;
      len_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rj_r        <= '0;
      wj_r        <= '0;
      mcnt_r      <= '0;
      ins_done_r  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        wsize_r <= cfg_window_size;
      end
      // In the hold state the hand-over below sets the output flag itself.
      if (out_valid_r && out_ready && (state_r != ST_HOLD)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            smp_r      <= smp_nxt;
            tag_r      <= wpos_eff;
            wpos_r     <= wpos_nxt;
            fill_r     <= fill_nxt;
            rj_r       <= '0;
            wj_r       <= '0;
            mcnt_r     <= '0;
            ins_done_r <= 1'b0;
            state_r    <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          // Address zero is presented; its entry shows in the next cycle.
          state_r <= ST_WALK;
        end
        ST_WALK: begin
          if (take_new) begin
            ins_done_r <= 1'b1;
          end
          if (consume) begin
            rj_r <= rj_r + CNTW'(1);
          end
          if (emit) begin
            wj_r <= wj_r + CNTW'(1);
            if (CNTW'(emit_tag) < fill_r) begin
              if (mcnt_r == med_pos) begin
                med_r <= emit_val;
              end
              mcnt_r <= mcnt_r + CNTW'(1);
            end
          end
          if (ins_done_r && !cur_valid) begin
            len_r   <= wj_r;
            bank_r  <= !bank_r;
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_med_r   <= med_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_med_r;

endmodule : running_median_filter

`default_nettype wire
